// ----- hw/rtl/ut2c_pkg.sv -----
// shared constants and types for the unix seconds to calendar date converter
`timescale 1ns / 1ps
`default_nettype none

package ut2c_pkg;

    // field widths
    localparam int ZONE_W = 5;
    localparam int SEC_FIELD_W = 6;
    localparam int MIN_FIELD_W = 6;
    localparam int HOUR_FIELD_W = 5;
    localparam int MDAY_FIELD_W = 5;
    localparam int MON_FIELD_W = 4;
    localparam int YEAR_FIELD_W = 8;

    // seconds to hours, one 20 bit digit per stage
    localparam int SEC_DIG_W = 20;
    localparam int HOUR_REM_W = 12;
    localparam int SECS_PER_HOUR = 3600;
    localparam int REC_HOUR_W = 21;
    localparam int REC_HOUR = 1193046;

    // remainder of the hour to minute and second
    localparam int SECS_PER_MIN = 60;
    localparam int REC_MIN_W = 7;
    localparam int REC_MIN = 68;

    // local hours to day number
    localparam int HOURS_PER_DAY = 24;
    localparam int DAY_SHIFT = 2472632;
    localparam int LOCAL_BIAS = HOURS_PER_DAY * DAY_SHIFT;

    // julian day decomposition
    localparam int DAYS_400Y = 146097;
    localparam int DAYS_400Y_REM_W = 18;
    localparam int DAYS_4Y = 1461;
    localparam int REC_4Y = 179;
    localparam int REC_4Y_W = 8;
    localparam int CENT_DAY_W = 16;
    localparam int YEAR_IDX_W = 8;
    localparam int DAYS_4Y_REM_W = 11;
    localparam int DAYS_5MON = 153;
    localparam int REC_5MON = 13;
    localparam int REC_5MON_W = 4;
    localparam int YEAR_DAY_W = 9;
    localparam int MCYC_W = 4;
    localparam int MCYC_REM_W = 8;
    localparam int REC_FIFTH = 205;
    localparam int REC_FIFTH_S = 10;
    localparam int MONTH_WRAP = 10;
    localparam int MONTH_OFFSET = 2;
    localparam int YEARS_PER_CENT = 100;
    localparam int YEAR_BASE = 6700;
    localparam int YEAR_SUM_W = 16;

    typedef struct packed {
        logic [HOUR_FIELD_W-1:0] hour;
        logic [MIN_FIELD_W-1:0]  minute;
        logic [SEC_FIELD_W-1:0]  second;
    } t_hms;

endpackage

`default_nettype wire

// ----- hw/rtl/ut2c_if.sv -----
// word channels of the converter: seconds in, date out, zone offset write
`timescale 1ns / 1ps
`default_nettype none

interface ut2c_sec_if #(
    parameter int SEC_W = 32
) ();
    logic             valid;
    logic             ready;
    logic [SEC_W-1:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink (input valid, input unix_seconds, output ready);
endinterface

interface ut2c_date_if
    import ut2c_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [SEC_FIELD_W-1:0]  second_of_minute;
    logic [MIN_FIELD_W-1:0]  minute_of_hour;
    logic [HOUR_FIELD_W-1:0] hour_of_day;
    logic [MDAY_FIELD_W-1:0] day_of_month;
    logic [MON_FIELD_W-1:0]  month_of_year;
    logic [YEAR_FIELD_W-1:0] years_since_1900;

    modport source (
        output valid, output second_of_minute, output minute_of_hour,
        output hour_of_day, output day_of_month, output month_of_year,
        output years_since_1900, input ready
    );
    modport sink (
        input valid, input second_of_minute, input minute_of_hour,
        input hour_of_day, input day_of_month, input month_of_year,
        input years_since_1900, output ready
    );
endinterface

interface ut2c_cfg_if
    import ut2c_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ZONE_W-1:0] zone_offset_hours;

    modport source (output valid, output zone_offset_hours, input ready);
    modport sink (input valid, input zone_offset_hours, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/unix_seconds_to_calendar_date.sv -----
// top level: unix seconds plus zone offset to local calendar date and time
// throughput: one word per cycle while the output is taken, bubbles are squeezed out when the output stalls
// the stages are the 20 bit digits of the divide by 3600, the local day split and
//   the 400 year, 4 year, five month and final field stages of the date
// reset clears all valid bits and sets the zone offset to zero, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module unix_seconds_to_calendar_date
    import ut2c_pkg::*;
#(
    parameter int SECONDS_WIDTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ut2c_cfg_if.sink      i_cfg,
    ut2c_sec_if.sink      i_sec,
    ut2c_date_if.source   o_date
);

    localparam int HR_W = SECONDS_WIDTH - 11;
    localparam int A_W = (SECONDS_WIDTH - 13 > 23) ? SECONDS_WIDTH - 13 : 23;
    localparam int NDIG = (SECONDS_WIDTH + SEC_DIG_W - 1) / SEC_DIG_W;
    localparam int N_ST = NDIG + 5;

    logic [ZONE_W-1:0]       r_zone;
    logic [N_ST-1:0]         en;
    logic [HR_W-1:0]         hours;
    logic [HOUR_REM_W-1:0]   hour_rem;
    logic [A_W-1:0]          day_num;
    t_hms                    hms_split;
    t_hms                    hms_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg.valid) begin
            r_zone <= i_cfg.zone_offset_hours;
        end
    end

    assign i_cfg.ready = 1'b1;

    ut2c_pipe_ctl #(
        .N_ST (N_ST)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sec.valid),
        .o_in_ready  (i_sec.ready),
        .i_out_ready (o_date.ready),
        .o_out_valid (o_date.valid),
        .o_en        (en)
    );

    ut2c_hour_div #(
        .SEC_W (SECONDS_WIDTH),
        .HR_W  (HR_W),
        .NDIG  (NDIG)
    ) u_hour_div (
        .i_clk   (i_clk),
        .i_en    (en[NDIG-1:0]),
        .i_secs  (i_sec.unix_seconds),
        .o_hours (hours),
        .o_rem   (hour_rem)
    );

    ut2c_day_split #(
        .HR_W (HR_W),
        .A_W  (A_W)
    ) u_day_split (
        .i_clk     (i_clk),
        .i_en      (en[NDIG]),
        .i_hours   (hours),
        .i_rem     (hour_rem),
        .i_zone    (r_zone),
        .o_day_num (day_num),
        .o_hms     (hms_split)
    );

    ut2c_date #(
        .A_W (A_W)
    ) u_date (
        .i_clk     (i_clk),
        .i_en      (en[N_ST-1:NDIG+1]),
        .i_day_num (day_num),
        .i_hms     (hms_split),
        .o_hms     (hms_out),
        .o_mday    (o_date.day_of_month),
        .o_mon     (o_date.month_of_year),
        .o_year    (o_date.years_since_1900)
    );

    assign o_date.second_of_minute = hms_out.second;
    assign o_date.minute_of_hour   = hms_out.minute;
    assign o_date.hour_of_day      = hms_out.hour;

endmodule

`default_nettype wire

// ----- hw/rtl/ut2c_pipe_ctl.sv -----
// valid bits and per-stage load enables of the conversion pipeline
`timescale 1ns / 1ps
`default_nettype none

module ut2c_pipe_ctl
    import ut2c_pkg::*;
#(
    parameter int N_ST = 7
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [N_ST-1:0]      o_en
);

    logic [N_ST-1:0] r_v;
    logic [N_ST-1:0] n_v;
    logic            in_fire;
    logic            out_fire;

    always_comb begin
        o_en[N_ST-1] = !r_v[N_ST-1] || i_out_ready;
        for (int i = N_ST - 2; i >= 0; i--) begin
            o_en[i] = !r_v[i] || o_en[i+1];
        end
    end

    always_comb begin
        n_v = r_v;
        if (o_en[0]) begin
            n_v[0] = i_in_valid;
        end
        for (int i = 1; i < N_ST; i++) begin
            if (o_en[i]) begin
                n_v[i] = r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready  = o_en[0];
    assign o_out_valid = r_v[N_ST-1];
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_v[N_ST-1] && i_out_ready;

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> $countones(r_v) == $past($countones(r_v))
            + int'($past(in_fire)) - int'($past(out_fire)))
        else $error("pipeline occupancy does not match words in and out");

    a_bubble_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_v) |-> o_in_ready)
        else $error("input stalled while the pipeline has a free stage");

    a_drain_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while the output is being taken");

endmodule

`default_nettype wire

// ----- hw/rtl/ut2c_hour_div.sv -----
// seconds divided by 3600, one 20 bit digit per pipeline stage
`timescale 1ns / 1ps
`default_nettype none

module ut2c_hour_div
    import ut2c_pkg::*;
#(
    parameter int SEC_W = 32,
    parameter int HR_W = 21,
    parameter int NDIG = 2
) (
    input  wire logic                  i_clk,
    input  wire logic [NDIG-1:0]       i_en,
    input  wire logic [SEC_W-1:0]      i_secs,
    output logic [HR_W-1:0]            o_hours,
    output logic [HOUR_REM_W-1:0]      o_rem
);

    localparam int PAD_W = NDIG * SEC_DIG_W;
    localparam int NUM_W = HOUR_REM_W + SEC_DIG_W;
    localparam int PROD_W = NUM_W + REC_HOUR_W;

    // remaining dividend digits on top, quotient digits shifted in below
    logic [PAD_W-1:0]      r_work [NDIG];
    logic [HOUR_REM_W-1:0] r_rem [NDIG];

    for (genvar j = 0; j < NDIG; j++) begin : g_dig
        logic [PAD_W-1:0]      work_in;
        logic [HOUR_REM_W-1:0] rem_in;
        logic [NUM_W-1:0]      num;
        logic [PROD_W-1:0]     prod;
        logic [REC_HOUR_W-1:0] q_est;
        logic [NUM_W-1:0]      r_est;
        logic [SEC_DIG_W-1:0]  n_dig;
        logic [HOUR_REM_W-1:0] n_rem;

        if (j == 0) begin : g_first
            assign work_in = PAD_W'(i_secs);
            assign rem_in  = '0;
        end else begin : g_next
            assign work_in = r_work[j-1];
            assign rem_in  = r_rem[j-1];
        end

        assign num   = {rem_in, work_in[PAD_W-1 -: SEC_DIG_W]};
        assign prod  = PROD_W'(num) * PROD_W'(REC_HOUR);
        assign q_est = prod[PROD_W-1 -: REC_HOUR_W];
        assign r_est = num - NUM_W'(PROD_W'(q_est) * PROD_W'(SECS_PER_HOUR));

        // estimate is low by at most one
        always_comb begin
            if (r_est >= NUM_W'(SECS_PER_HOUR)) begin
                n_dig = SEC_DIG_W'(q_est + 1'b1);
                n_rem = HOUR_REM_W'(r_est - NUM_W'(SECS_PER_HOUR));
            end else begin
                n_dig = SEC_DIG_W'(q_est);
                n_rem = HOUR_REM_W'(r_est);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_work[j] <= {work_in[PAD_W-SEC_DIG_W-1:0], n_dig};
                r_rem[j]  <= n_rem;
            end
        end
    end

    assign o_hours = r_work[NDIG-1][HR_W-1:0];
    assign o_rem   = r_rem[NDIG-1];

endmodule

`default_nettype wire

// ----- hw/rtl/ut2c_day_split.sv -----
// local hour count to shifted day number and hour, hour remainder to minute and second
`timescale 1ns / 1ps
`default_nettype none

module ut2c_day_split
    import ut2c_pkg::*;
#(
    parameter int HR_W = 21,
    parameter int A_W = 23
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [HR_W-1:0]       i_hours,
    input  wire logic [HOUR_REM_W-1:0] i_rem,
    input  wire logic [ZONE_W-1:0]     i_zone,
    output logic [A_W-1:0]             o_day_num,
    output t_hms                       o_hms
);

    localparam int LP_W = A_W + 5;
    localparam int S3 = A_W + 2;
    localparam int P3_W = 2 * S3;
    localparam longint unsigned M3 = (64'd1 << S3) / 3;
    localparam int PM_W = HOUR_REM_W + REC_MIN_W;

    logic [LP_W-1:0]       lp;
    logic [S3-1:0]         l3;
    logic [P3_W-1:0]       prod3;
    logic [S3-1:0]         q3;
    logic [S3-1:0]         r3;
    logic [A_W-1:0]        n_day_num;
    logic [1:0]            r3_fix;
    logic [PM_W-1:0]       prod_m;
    logic [REC_MIN_W-1:0]  q_m;
    logic [HOUR_REM_W-1:0] r_m;
    t_hms                  n_hms;
    logic [A_W-1:0]        r_day_num;
    t_hms                  r_hms;

    // bias keeps the sum positive and already holds the day shift
    assign lp = LP_W'(i_hours) + {{(LP_W-ZONE_W){i_zone[ZONE_W-1]}}, i_zone}
              + LP_W'(LOCAL_BIAS);

    // divide by 24 as a shift by three and a divide by three
    assign l3    = lp[LP_W-1:3];
    assign prod3 = P3_W'(l3) * P3_W'(M3);
    assign q3    = prod3[P3_W-1 -: S3];
    assign r3    = l3 - S3'(P3_W'(q3) * P3_W'(3));

    always_comb begin
        if (r3 >= S3'(3)) begin
            n_day_num = A_W'(q3 + 1'b1);
            r3_fix    = 2'(r3 - S3'(3));
        end else begin
            n_day_num = A_W'(q3);
            r3_fix    = 2'(r3);
        end
    end

    assign prod_m = PM_W'(i_rem) * PM_W'(REC_MIN);
    assign q_m    = prod_m[PM_W-1 -: REC_MIN_W];
    assign r_m    = i_rem - HOUR_REM_W'(HOUR_REM_W'(q_m) * HOUR_REM_W'(SECS_PER_MIN));

    always_comb begin
        n_hms.hour = {r3_fix, lp[2:0]};
        if (r_m >= HOUR_REM_W'(SECS_PER_MIN)) begin
            n_hms.minute = MIN_FIELD_W'(q_m + 1'b1);
            n_hms.second = SEC_FIELD_W'(r_m - HOUR_REM_W'(SECS_PER_MIN));
        end else begin
            n_hms.minute = MIN_FIELD_W'(q_m);
            n_hms.second = SEC_FIELD_W'(r_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_day_num <= n_day_num;
            r_hms     <= n_hms;
        end
    end

    assign o_day_num = r_day_num;
    assign o_hms     = r_hms;

endmodule

`default_nettype wire

// ----- hw/rtl/ut2c_date.sv -----
// shifted day number to day, month and year in four pipeline stages
`timescale 1ns / 1ps
`default_nettype none

module ut2c_date
    import ut2c_pkg::*;
#(
    parameter int A_W = 23
) (
    input  wire logic                    i_clk,
    input  wire logic [3:0]              i_en,
    input  wire logic [A_W-1:0]          i_day_num,
    input  wire t_hms                    i_hms,
    output t_hms                         o_hms,
    output logic [MDAY_FIELD_W-1:0]      o_mday,
    output logic [MON_FIELD_W-1:0]       o_mon,
    output logic [YEAR_FIELD_W-1:0]      o_year
);

    localparam int SB = A_W + 2;
    localparam int B_W = SB - 17;
    localparam int PB_W = SB + B_W;
    localparam longint unsigned MB = (64'd1 << SB) / DAYS_400Y;
    localparam int PC_W = DAYS_400Y_REM_W + REC_4Y_W;
    localparam int PD_W = DAYS_4Y_REM_W + REC_5MON_W;
    localparam int PE_W = 16;

    // 400 year cycle
    logic [SB-1:0]              nb;
    logic [PB_W-1:0]            prod_b;
    logic [B_W-1:0]             q_b;
    logic [SB-1:0]              rb_est;
    logic [B_W-1:0]             n_b;
    logic [DAYS_400Y_REM_W-1:0] n_rb;
    logic [B_W-1:0]             r_b;
    logic [DAYS_400Y_REM_W-1:0] r_rb;
    t_hms                       r_hms_b;

    // 4 year cycle
    logic [DAYS_400Y_REM_W-1:0] c_sum;
    logic [DAYS_400Y_REM_W-1:0] nc;
    logic [PC_W-1:0]            prod_c;
    logic [REC_4Y_W-1:0]        q_c;
    logic [DAYS_400Y_REM_W-1:0] rc_est;
    logic [YEAR_IDX_W-1:0]      n_d;
    logic [DAYS_4Y_REM_W-1:0]   n_rc;
    logic [B_W-1:0]             r_b_c;
    logic [YEAR_IDX_W-1:0]      r_d;
    logic [DAYS_4Y_REM_W-1:0]   r_rc;
    t_hms                       r_hms_c;

    // five month cycle
    logic [DAYS_4Y_REM_W-1:0]   e_sum;
    logic [YEAR_DAY_W-1:0]      e;
    logic [DAYS_4Y_REM_W-1:0]   nd;
    logic [PD_W-1:0]            prod_d;
    logic [REC_5MON_W-1:0]      q_d;
    logic [DAYS_4Y_REM_W-1:0]   rd_est;
    logic [MCYC_W-1:0]          n_m;
    logic [MCYC_REM_W-1:0]      n_rd;
    logic [B_W-1:0]             r_b_d;
    logic [YEAR_IDX_W-1:0]      r_d_d;
    logic [MCYC_W-1:0]          r_m;
    logic [MCYC_REM_W-1:0]      r_rd;
    t_hms                       r_hms_d;

    // final fields
    logic [PE_W-1:0]            prod_e;
    logic                       wrap;
    logic [YEAR_SUM_W-1:0]      year_sum;
    logic [MDAY_FIELD_W-1:0]    n_mday;
    logic [MON_FIELD_W-1:0]     n_mon;
    logic [MDAY_FIELD_W-1:0]    r_mday;
    logic [MON_FIELD_W-1:0]     r_mon;
    logic [YEAR_FIELD_W-1:0]    r_year;
    t_hms                       r_hms_e;

    assign nb     = {i_day_num, 2'b11};
    assign prod_b = PB_W'(nb) * PB_W'(MB);
    assign q_b    = prod_b[PB_W-1 -: B_W];
    assign rb_est = nb - SB'(PB_W'(q_b) * PB_W'(DAYS_400Y));

    always_comb begin
        if (rb_est >= SB'(DAYS_400Y)) begin
            n_b  = q_b + 1'b1;
            n_rb = DAYS_400Y_REM_W'(rb_est - SB'(DAYS_400Y));
        end else begin
            n_b  = q_b;
            n_rb = DAYS_400Y_REM_W'(rb_est);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_b     <= n_b;
            r_rb    <= n_rb;
            r_hms_b <= i_hms;
        end
    end

    // day within the 400 year cycle from the remainder and b mod 4
    assign c_sum  = r_rb + DAYS_400Y_REM_W'(r_b[1:0]) - DAYS_400Y_REM_W'(3);
    assign nc     = {c_sum[DAYS_400Y_REM_W-1:2], 2'b11};
    assign prod_c = PC_W'(nc) * PC_W'(REC_4Y);
    assign q_c    = prod_c[PC_W-1 -: REC_4Y_W];
    assign rc_est = nc - DAYS_400Y_REM_W'(PC_W'(q_c) * PC_W'(DAYS_4Y));

    always_comb begin
        if (rc_est >= DAYS_400Y_REM_W'(DAYS_4Y)) begin
            n_d  = YEAR_IDX_W'(q_c + 1'b1);
            n_rc = DAYS_4Y_REM_W'(rc_est - DAYS_400Y_REM_W'(DAYS_4Y));
        end else begin
            n_d  = YEAR_IDX_W'(q_c);
            n_rc = DAYS_4Y_REM_W'(rc_est);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_c   <= r_b;
            r_d     <= n_d;
            r_rc    <= n_rc;
            r_hms_c <= r_hms_b;
        end
    end

    // day within the 4 year cycle from the remainder and d mod 4
    assign e_sum  = r_rc + DAYS_4Y_REM_W'(r_d[1:0]) - DAYS_4Y_REM_W'(3);
    assign e      = e_sum[DAYS_4Y_REM_W-1:2];
    assign nd     = DAYS_4Y_REM_W'(DAYS_4Y_REM_W'(e) * DAYS_4Y_REM_W'(5))
                  + DAYS_4Y_REM_W'(2);
    assign prod_d = PD_W'(nd) * PD_W'(REC_5MON);
    assign q_d    = prod_d[PD_W-1 -: REC_5MON_W];
    assign rd_est = nd - DAYS_4Y_REM_W'(DAYS_4Y_REM_W'(q_d) * DAYS_4Y_REM_W'(DAYS_5MON));

    always_comb begin
        if (rd_est >= DAYS_4Y_REM_W'(DAYS_5MON)) begin
            n_m  = MCYC_W'(q_d + 1'b1);
            n_rd = MCYC_REM_W'(rd_est - DAYS_4Y_REM_W'(DAYS_5MON));
        end else begin
            n_m  = MCYC_W'(q_d);
            n_rd = MCYC_REM_W'(rd_est);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_b_d   <= r_b_c;
            r_d_d   <= r_d;
            r_m     <= n_m;
            r_rd    <= n_rd;
            r_hms_d <= r_hms_c;
        end
    end

    // day of month is the five month remainder over five, plus one
    assign prod_e = PE_W'(r_rd) * PE_W'(REC_FIFTH);
    assign n_mday = MDAY_FIELD_W'(prod_e[PE_W-1:REC_FIFTH_S]) + MDAY_FIELD_W'(1);
    assign wrap   = (r_m >= MCYC_W'(MONTH_WRAP));

    always_comb begin
        if (wrap) begin
            n_mon = MON_FIELD_W'(r_m - MCYC_W'(MONTH_WRAP));
        end else begin
            n_mon = MON_FIELD_W'(r_m + MCYC_W'(MONTH_OFFSET));
        end
    end

    assign year_sum = YEAR_SUM_W'(YEAR_SUM_W'(r_b_d) * YEAR_SUM_W'(YEARS_PER_CENT))
                    + YEAR_SUM_W'(r_d_d) + YEAR_SUM_W'(wrap)
                    - YEAR_SUM_W'(YEAR_BASE);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_mday  <= n_mday;
            r_mon   <= n_mon;
            r_year  <= year_sum[YEAR_FIELD_W-1:0];
            r_hms_e <= r_hms_d;
        end
    end

    assign o_hms  = r_hms_e;
    assign o_mday = r_mday;
    assign o_mon  = r_mon;
    assign o_year = r_year;

endmodule

`default_nettype wire
